[design/crc8fd_pkg.sv]
// ============================================================================
// crc8fd_pkg
// Shared types, codes and the CRC-8 byte update for the CRC-8 frame decoder.
// ============================================================================
package crc8fd_pkg;

    // CRC-8, polynomial x^8 + x^2 + x + 1, MSB first
    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_TOP  = 8'h80;

    // Version register value after reset
    localparam logic [7:0] VERSION_RESET = 8'h01;

    // Frame header positions
    localparam int unsigned POS_COMMAND     = 0;
    localparam int unsigned POS_VERSION     = 1;
    localparam int unsigned POS_TRANSACTION = 2;
    localparam int unsigned POS_FIRST_BODY  = 3;

    // Kind of result request
    typedef enum logic {
        KIND_BODY    = 1'b0,
        KIND_VERDICT = 1'b1
    } t_kind;

    // Verdict status codes
    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_BAD_LENGTH  = 2'd1,
        STATUS_CRC_ERROR   = 2'd2,
        STATUS_BAD_VERSION = 2'd3
    } t_status;

    // One result request
    typedef struct packed {
        t_kind      result_kind;
        logic [7:0] body_byte;
        logic [7:0] command_code;
        logic [7:0] transaction_tag;
        logic [7:0] body_count;
        t_status    frame_status;
    } t_result;

    // CRC-8 over one byte, unrolled to eight shift/xor steps
    function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                               input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 8'h00) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

[design/crc8fd_if.sv]
// ============================================================================
// crc8fd interfaces
// Valid/ready channels for frame bytes, results and the version register.
// ============================================================================

// Frame byte channel
interface crc8fd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

// Result channel
interface crc8fd_out_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] body_byte;
    logic [7:0] command_code;
    logic [7:0] transaction_tag;
    logic [7:0] body_count;
    logic [1:0] frame_status;

    modport source (output valid, output result_kind, output body_byte,
                    output command_code, output transaction_tag,
                    output body_count, output frame_status, input ready);
    modport sink   (input valid, input result_kind, input body_byte,
                    input command_code, input transaction_tag,
                    input body_count, input frame_status, output ready);
endinterface

// Version register write channel
interface crc8fd_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] expected_version;

    modport source (output valid, output expected_version, input ready);
    modport sink   (input valid, input expected_version, output ready);
endinterface

[design/crc8fd_core.sv]
// ============================================================================
// crc8fd_core
// Frame state (position, running CRC, header bytes) and the result for one
// byte, computed in a single pass.
// ============================================================================
module crc8fd_core
    import crc8fd_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic [7:0] i_expected_version,
    output logic       o_emit,
    output t_result    o_result
);

    localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int unsigned BW    = (POS_W > 8) ? POS_W : 8;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_crc, n_crc;
    logic [7:0]       r_cmd, n_cmd;
    logic [7:0]       r_ver, n_ver;
    logic [7:0]       r_tid, n_tid;

    logic             in_body;
    logic [BW-1:0]    body_wide;
    t_status          status;

    assign in_body   = (r_pos >= POS_W'(POS_FIRST_BODY));
    assign body_wide = BW'(r_pos) - BW'(POS_FIRST_BODY);

    // Verdict checks: length, then CRC, then version
    always_comb begin
        if (!in_body || (r_pos >= POS_MAX)) begin
            status = STATUS_BAD_LENGTH;
        end else if (r_crc != i_byte) begin
            status = STATUS_CRC_ERROR;
        end else if (r_ver != i_expected_version) begin
            status = STATUS_BAD_VERSION;
        end else begin
            status = STATUS_OK;
        end
    end

    // Result and next frame state
    always_comb begin
        o_result = '0;
        o_emit   = i_last || in_body;
        n_pos    = r_pos;
        n_crc    = r_crc;
        n_cmd    = r_cmd;
        n_ver    = r_ver;
        n_tid    = r_tid;
        if (i_last) begin
            o_result.result_kind  = KIND_VERDICT;
            o_result.frame_status = status;
            if (status == STATUS_OK) begin
                o_result.command_code    = r_cmd;
                o_result.transaction_tag = r_tid;
                o_result.body_count      = (body_wide > BW'(255)) ? 8'hFF : body_wide[7:0];
            end
            n_pos = '0;
            n_crc = '0;
            n_cmd = '0;
            n_ver = '0;
            n_tid = '0;
        end else begin
            o_result.result_kind = KIND_BODY;
            o_result.body_byte   = i_byte;
            if (r_pos == POS_W'(POS_COMMAND)) begin
                n_cmd = i_byte;
            end
            if (r_pos == POS_W'(POS_VERSION)) begin
                n_ver = i_byte;
            end
            if (r_pos == POS_W'(POS_TRANSACTION)) begin
                n_tid = i_byte;
            end
            n_crc = crc8_update(r_crc, i_byte);
            // counter saturates at the maximum frame length
            if (r_pos < POS_MAX) begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    // Frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_crc <= '0;
            r_cmd <= '0;
            r_ver <= '0;
            r_tid <= '0;
        end else if (i_step) begin
            r_pos <= n_pos;
            r_crc <= n_crc;
            r_cmd <= n_cmd;
            r_ver <= n_ver;
            r_tid <= n_tid;
        end
    end

endmodule

[design/crc8_frame_decoder_unit.sv]
// ============================================================================
// crc8_frame_decoder_unit
// CRC-8 checked frame decoder: body bytes pass through, final byte yields a
// verdict with command, transaction id, body length and status.
// ============================================================================
// The block takes one frame byte per clock cycle and sustains that rate with
// no gaps while the result channel is not stalled. A byte goes into an input
// register, its result is formed in one pass (one byte of CRC-8 as eight
// unrolled XOR steps, and the verdict compares) and written into the output
// register. Header bytes and non-final bytes of short frames give no result.
// The input ready follows the output ready within the same cycle when both
// registers are full and the held byte gives a result. The version register is
// written through its own channel, always ready, and should be written only
// while no frame is in flight.
module crc8_frame_decoder_unit
    import crc8fd_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    crc8fd_in_if.sink       i_in,
    crc8fd_out_if.source    o_out,
    crc8fd_cfg_if.sink      i_cfg
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    logic [7:0] r_expected_version;

    logic       emit;
    logic       advance;
    t_result    result;

    // Frame processing
    crc8fd_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (advance),
        .i_byte             (r_in_byte),
        .i_last             (r_in_last),
        .i_expected_version (r_expected_version),
        .o_emit             (emit),
        .o_result           (result)
    );

    // Held byte moves on when it needs no output slot or the slot frees up
    assign advance    = r_in_valid && (!emit || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.frame_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out <= result;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.result_kind     = r_out.result_kind;
    assign o_out.body_byte       = r_out.body_byte;
    assign o_out.command_code    = r_out.command_code;
    assign o_out.transaction_tag = r_out.transaction_tag;
    assign o_out.body_count      = r_out.body_count;
    assign o_out.frame_status    = r_out.frame_status;

    // Version register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_version <= VERSION_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_expected_version <= i_cfg.expected_version;
        end
    end

endmodule

[design/crc8fd_checker.sv]
// ============================================================================
// crc8fd_checker
// Port-level checks on the result channel of the CRC-8 frame decoder.
// ============================================================================
module crc8fd_checker
    import crc8fd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic       i_result_kind,
    input  logic [7:0] i_body_byte,
    input  logic [7:0] i_command_code,
    input  logic [7:0] i_transaction_tag,
    input  logic [7:0] i_body_count,
    input  logic [1:0] i_frame_status
);

    // Stalled request stays up and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_result_kind)
            && $stable(i_body_byte) && $stable(i_command_code)
            && $stable(i_transaction_tag) && $stable(i_body_count)
            && $stable(i_frame_status))
        else $error("result request changed while stalled");

    // Body request carries only the byte
    a_body_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_result_kind == KIND_BODY) |->
            (i_command_code == 8'h00) && (i_transaction_tag == 8'h00)
            && (i_body_count == 8'h00) && (i_frame_status == STATUS_OK))
        else $error("body request with verdict fields set");

    // Verdict carries no body byte
    a_verdict_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_result_kind == KIND_VERDICT) |-> (i_body_byte == 8'h00))
        else $error("verdict with body byte set");

    // Failed verdict reports no header fields
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_result_kind == KIND_VERDICT) && (i_frame_status != STATUS_OK)
            |-> (i_command_code == 8'h00) && (i_transaction_tag == 8'h00)
                && (i_body_count == 8'h00))
        else $error("failed verdict with header fields set");

endmodule

bind crc8_frame_decoder_unit crc8fd_checker u_crc8fd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_result_kind     (o_out.result_kind),
    .i_body_byte       (o_out.body_byte),
    .i_command_code    (o_out.command_code),
    .i_transaction_tag (o_out.transaction_tag),
    .i_body_count      (o_out.body_count),
    .i_frame_status    (o_out.frame_status)
);

[test/tb_top.sv]
// ============================================================================
// tb_top
// Testbench for the CRC-8 frame decoder. A directed table covers short,
// minimal, bad-CRC and bad-version frames. Random frames follow, mostly
// well formed with random content, plus short, overlong and noise frames.
// The version register changes between phases, and both handshakes are
// throttled at random. A byte-level decoder model predicts every result
// request, and each one is checked field by field in arrival order.
// ============================================================================
module tb_top;
    import crc8fd_pkg::*;

    localparam int unsigned FRAME_MAX     = 256;
    localparam int          PHASE_BYTES   = 225;
    localparam int          SETTLE_CYCLES = 6;
    localparam int          STALL_LIMIT   = 2000;

    // Source of the final byte in a directed row
    typedef enum logic [1:0] {
        CRC_AS_GIVEN = 2'd0,
        CRC_CORRECT  = 2'd1,
        CRC_WRONG    = 2'd2
    } t_crc_fill;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        t_crc_fill  fill;
        logic       typed;
        t_status    status;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    crc8fd_in_if  in_ch ();
    crc8fd_out_if out_ch ();
    crc8fd_cfg_if cfg_ch ();

    crc8_frame_decoder_unit #(
        .MAX_FRAME_BYTES(FRAME_MAX)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    // Decoder model state
    logic [8:0] frame_pos   = '0;
    logic [7:0] frame_crc   = '0;
    logic [7:0] hold_cmd    = '0;
    logic [7:0] hold_ver    = '0;
    logic [7:0] hold_tag    = '0;
    logic [7:0] version_reg = VERSION_RESET;

    t_result expected_results[$];
    int      mismatches     = 0;
    int      bytes_sent     = 0;
    int      quiet_cycles   = 0;
    int      src_idle_pct   = 0;
    int      sink_stall_pct = 0;

    // Short frames, minimal frame, body extremes, CRC and version failures
    t_stim_row directed_rows [26] = '{
        '{8'h00, 1'b1, CRC_AS_GIVEN, 1'b1, STATUS_BAD_LENGTH},
        '{8'h5A, 1'b0, CRC_AS_GIVEN, 1'b0, STATUS_OK},
        '{8'h01, 1'b0, CRC_AS_GIVEN, 1'b0, STATUS_OK},
        '{8'hFF, 1'b1, CRC_AS_GIVEN, 1'b1, STATUS_BAD_LENGTH},
        '{8'hFF, 1'b0, CRC_AS_GIVEN, 1'b0, STATUS_OK},
        '{8'h01, 1'b0, CRC_AS_GIVEN, 1'b0, STATUS_OK},
        '{8'hFF, 1'b0, CRC_AS_GIVEN, 1'b0, STATUS_OK},
        '{8'h00, 1'b1, CRC_CORRECT,  1'b0, STATUS_OK},
        '{8'h00, 1'b0, CRC_AS_GIVEN, 1'b0, STATUS_OK},
        '{8'h01, 1'b0, CRC_AS_GIVEN, 1'b0, STATUS_OK},
        '{8'h00, 1'b0, CRC_AS_GIVEN, 1'b0, STATUS_OK},
        '{8'hFF, 1'b0, CRC_AS_GIVEN, 1'b0, STATUS_OK},
        '{8'h00, 1'b0, CRC_AS_GIVEN, 1'b0, STATUS_OK},
        '{8'h00, 1'b1, CRC_CORRECT,  1'b0, STATUS_OK},
        '{8'h12, 1'b0, CRC_AS_GIVEN, 1'b0, STATUS_OK},
        '{8'h01, 1'b0, CRC_AS_GIVEN, 1'b0, STATUS_OK},
        '{8'h34, 1'b0, CRC_AS_GIVEN, 1'b0, STATUS_OK},
        '{8'hA5, 1'b0, CRC_AS_GIVEN, 1'b0, STATUS_OK},
        '{8'h00, 1'b1, CRC_WRONG,    1'b1, STATUS_CRC_ERROR},
        '{8'h12, 1'b0, CRC_AS_GIVEN, 1'b0, STATUS_OK},
        '{8'hFE, 1'b0, CRC_AS_GIVEN, 1'b0, STATUS_OK},
        '{8'h34, 1'b0, CRC_AS_GIVEN, 1'b0, STATUS_OK},
        '{8'h00, 1'b1, CRC_CORRECT,  1'b1, STATUS_BAD_VERSION},
        '{8'h77, 1'b0, CRC_AS_GIVEN, 1'b0, STATUS_OK},
        '{8'h02, 1'b0, CRC_AS_GIVEN, 1'b0, STATUS_OK},
        '{8'h00, 1'b1, CRC_WRONG,    1'b1, STATUS_BAD_LENGTH}
    };

    // Clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // CRC-8, poly 0x07, MSB first: feed one data bit per shift
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] acc;
        logic       fb;
        acc = crc;
        for (int i = 7; i >= 0; i--) begin
            fb  = acc[7] ^ data[i];
            acc = {acc[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
        end
        return acc;
    endfunction

    // Advance the decoder model by one byte; returns 1 when a request is due
    function automatic bit decode_byte(input logic [7:0] data, input logic last,
                                       output t_result res);
        int length;
        res = '0;
        if (!last) begin
            if (frame_pos == POS_COMMAND) begin
                hold_cmd = data;
            end else if (frame_pos == POS_VERSION) begin
                hold_ver = data;
            end else if (frame_pos == POS_TRANSACTION) begin
                hold_tag = data;
            end
            frame_crc = crc8_step(frame_crc, data);
            res.result_kind  = KIND_BODY;
            res.body_byte    = data;
            res.frame_status = STATUS_OK;
            if (frame_pos >= POS_FIRST_BODY) begin
                if (frame_pos < FRAME_MAX) frame_pos = frame_pos + 1'b1;
                return 1'b1;
            end
            frame_pos = frame_pos + 1'b1;
            return 1'b0;
        end
        length = int'(frame_pos) + 1;
        res.result_kind = KIND_VERDICT;
        if (length < 4 || length > FRAME_MAX) begin
            res.frame_status = STATUS_BAD_LENGTH;
        end else if (frame_crc != data) begin
            res.frame_status = STATUS_CRC_ERROR;
        end else if (hold_ver != version_reg) begin
            res.frame_status = STATUS_BAD_VERSION;
        end else begin
            res.frame_status    = STATUS_OK;
            res.command_code    = hold_cmd;
            res.transaction_tag = hold_tag;
            res.body_count      = (length - 4 > 255) ? 8'd255 : 8'(length - 4);
        end
        frame_pos = '0;
        frame_crc = '0;
        hold_cmd  = '0;
        hold_ver  = '0;
        hold_tag  = '0;
        return 1'b1;
    endfunction

    // Send one frame byte; a typed row overrides the model's verdict
    task automatic push_frame_byte(input logic [7:0] data, input logic last,
                                   input logic typed, input t_status status);
        t_result res;
        bit      has_res;
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.frame_byte <= data;
        in_ch.last_byte  <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        bytes_sent++;
        has_res = decode_byte(data, last, res);
        if (typed) begin
            res              = '0;
            res.result_kind  = KIND_VERDICT;
            res.frame_status = status;
        end
        if (has_res) expected_results.push_back(res);
    endtask

    // One random frame: mostly well formed, some short, overlong or noise
    task automatic send_random_frame();
        int         kind;
        int         len;
        logic [7:0] hdr_ver;
        bit         good_crc;
        kind     = $urandom_range(99);
        good_crc = ($urandom_range(9) != 0);
        hdr_ver  = ($urandom_range(4) != 0) ? version_reg : 8'($urandom);
        if (kind < 72) begin
            len = ($urandom_range(49) == 0) ? $urandom_range(250, FRAME_MAX)
                                            : $urandom_range(4, 16);
        end else if (kind < 84) begin
            len = $urandom_range(1, 3);
        end else if (kind < 87) begin
            len = $urandom_range(FRAME_MAX + 1, FRAME_MAX + 12);
        end else begin
            len      = $urandom_range(1, 20);
            good_crc = ($urandom_range(3) == 0);
            hdr_ver  = 8'($urandom);
        end
        for (int i = 0; i < len - 1; i++) begin
            push_frame_byte((i == POS_VERSION) ? hdr_ver : 8'($urandom), 1'b0, 1'b0, STATUS_OK);
        end
        push_frame_byte(good_crc ? frame_crc : 8'($urandom), 1'b1, 1'b0, STATUS_OK);
    endtask

    // Stop sending and let every outstanding request arrive
    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_version(input logic [7:0] value);
        cfg_ch.valid            <= 1'b1;
        cfg_ch.expected_version <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        version_reg = value;
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Result receiver: random stalls per phase
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Result checker
    always @(posedge i_clk) begin
        t_result want;
        if (out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                $error("result request with nothing expected");
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("result_kind", 8'(want.result_kind), 8'(out_ch.result_kind));
                check_field("body_byte", want.body_byte, out_ch.body_byte);
                check_field("command_code", want.command_code, out_ch.command_code);
                check_field("transaction_tag", want.transaction_tag, out_ch.transaction_tag);
                check_field("body_count", want.body_count, out_ch.body_count);
                check_field("frame_status", 8'(want.frame_status), 8'(out_ch.frame_status));
            end
        end
    end

    // Watchdog: no request on any channel for too long
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence
    initial begin
        logic [7:0] data;
        int         start_count;
        i_rst_n                 <= 1'b0;
        in_ch.valid             <= 1'b0;
        in_ch.frame_byte        <= '0;
        in_ch.last_byte         <= 1'b0;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.expected_version <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table at the reset version, no throttling
        foreach (directed_rows[i]) begin
            case (directed_rows[i].fill)
                CRC_CORRECT: data = frame_crc;
                CRC_WRONG:   data = frame_crc ^ 8'h01;
                default:     data = directed_rows[i].data;
            endcase
            push_frame_byte(data, directed_rows[i].last, directed_rows[i].typed,
                            directed_rows[i].status);
        end

        // Random phases: new version each time, rotating throttle patterns
        for (int phase = 0; phase < 6; phase++) begin
            wait_results_drained();
            case (phase)
                0:       write_version(8'h00);
                1:       write_version(8'hFF);
                default: write_version(8'($urandom));
            endcase
            case (phase % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 63; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 63; end
                default: begin src_idle_pct = 20; sink_stall_pct = 20; end
            endcase
            start_count = bytes_sent;
            while (bytes_sent - start_count < PHASE_BYTES) send_random_frame();
        end

        wait_results_drained();
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
